FILE: hdl/pixel_run_length_encoder_core_defines.svh
// Assertion macros used by the pixel run-length encoder controller.
`ifndef PIXEL_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH
`define PIXEL_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH

// Condition and consequence checked in the same cycle.
`define PRLE_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the condition.
`define PRLE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/prle_pkg.sv
// Shared constants and control types of the pixel run-length encoder.
package prle_pkg;

    localparam int MAX_RUN  = 127;
    localparam int RUN_W    = 7;
    localparam int LANES    = 4;
    localparam int BANK_W   = 2;
    localparam int ROW_W    = RUN_W - BANK_W;
    localparam int NUM_ROWS = 2 ** ROW_W;
    localparam int PIX_W    = 32;
    localparam int HDR_W    = 8;
    localparam int TAKE_W   = 3;
    localparam int CH_W     = 3;

    localparam logic [RUN_W-1:0] MAX_RUN_L  = RUN_W'(MAX_RUN);
    localparam logic [CH_W-1:0]  CH_RGB     = 3'd3;
    localparam logic [HDR_W-1:0] HDR_SINGLE = 8'd1;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_S0,
        SRC_S1
    } t_src;

    typedef struct packed {
        logic              accept;
        logic              we1;
        logic [RUN_W-1:0]  wa1;
        logic              we2;
        logic [RUN_W-1:0]  wa2;
        logic              s0_old;
        logic              load;
        t_src              src;
        logic [ROW_W-1:0]  row;
        logic [TAKE_W-1:0] take;
        logic              has_header;
        logic [HDR_W-1:0]  header;
        logic              last;
        logic              done;
    } t_dp_cmd;

    typedef struct packed {
        logic eq;
        logic ld_ok;
    } t_dp_status;

endpackage

FILE: hdl/prle_dp.sv
// Datapath: held pixel, banked literal store, single-pixel slots and the output register.
module prle_dp
    import prle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CH_W-1:0]   i_cfg_data,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_out_stall,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output logic              o_has_header,
    output logic [HDR_W-1:0]  o_header,
    output logic [TAKE_W-1:0] o_pixel_count,
    output logic [PIX_W-1:0]  o_pixel_a,
    output logic [PIX_W-1:0]  o_pixel_b,
    output logic [PIX_W-1:0]  o_pixel_c,
    output logic [PIX_W-1:0]  o_pixel_d,
    output logic              o_last_of_step,
    output logic              o_image_done
);

    logic [CH_W-1:0]   r_channels;
    logic [PIX_W-1:0]  r_held;
    logic [PIX_W-1:0]  r_s0_pix;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [PIX_W-1:0]  r_mem [LANES][NUM_ROWS];
    logic              r_out_valid;
    logic              r_has_header;
    logic [HDR_W-1:0]  r_header;
    logic [TAKE_W-1:0] r_count;
    logic [PIX_W-1:0]  r_slot [LANES];
    logic              r_last;
    logic              r_done;
    logic [PIX_W-1:0]  q;

    // In RGB mode the top byte is dropped on arrival.
    assign q = (r_channels <= CH_RGB) ? {8'h00, i_pixel[23:0]} : i_pixel;

    assign o_status.eq    = (r_held == q);
    assign o_status.ld_ok = !r_out_valid || !i_out_stall;
    assign o_cfg_ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels  <= CH_RGB;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_channels <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_held   <= q;
            r_s0_pix <= i_cmd.s0_old ? r_held : q;
            r_s1_pix <= q;
        end
    end

    // Two writes of one transaction always hit consecutive addresses, hence different banks.
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < LANES; b++) begin
            if (i_cmd.accept && i_cmd.we1 && (i_cmd.wa1[BANK_W-1:0] == BANK_W'(b))) begin
                r_mem[b][i_cmd.wa1[RUN_W-1:BANK_W]] <= r_held;
            end else if (i_cmd.accept && i_cmd.we2
                         && (i_cmd.wa2[BANK_W-1:0] == BANK_W'(b))) begin
                r_mem[b][i_cmd.wa2[RUN_W-1:BANK_W]] <= q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_has_header <= i_cmd.has_header;
            r_header     <= i_cmd.header;
            r_count      <= i_cmd.take;
            r_last       <= i_cmd.last;
            r_done       <= i_cmd.done;
            for (int j = 0; j < LANES; j++) begin
                case (i_cmd.src)
                    SRC_LIT: begin
                        r_slot[j] <= (TAKE_W'(j) < i_cmd.take) ? r_mem[j][i_cmd.row] : '0;
                    end
                    SRC_S0: begin
                        r_slot[j] <= (j == 0) ? r_s0_pix : '0;
                    end
                    SRC_S1: begin
                        r_slot[j] <= (j == 0) ? r_s1_pix : '0;
                    end
                    default: begin
                        r_slot[j] <= '0;
                    end
                endcase
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_header   = r_has_header;
    assign o_header       = r_header;
    assign o_pixel_count  = r_count;
    assign o_pixel_a      = r_slot[0];
    assign o_pixel_b      = r_slot[1];
    assign o_pixel_c      = r_slot[2];
    assign o_pixel_d      = r_slot[3];
    assign o_last_of_step = r_last;
    assign o_image_done   = r_done;

endmodule

FILE: hdl/prle_ctrl.sv
// Controller: run state machine and the sequencer that emits each packet.
`include "pixel_run_length_encoder_core_defines.svh"

module prle_ctrl
    import prle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_final_pixel,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIT,
        S_SNG0,
        S_SNG1
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LIT,
        M_REP
    } t_mode;

    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [RUN_W-1:0] r_rl, n_rl;
    logic             r_hv, n_hv;
    logic [RUN_W-1:0] r_lit_cnt, n_lit_cnt;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_s0_go, n_s0_go;
    logic [HDR_W-1:0] r_s0_hdr, n_s0_hdr;
    logic             r_s1_go, n_s1_go;
    logic [HDR_W-1:0] r_s1_hdr, n_s1_hdr;
    logic             r_fin, n_fin;

    t_mode            mid_mode;
    logic [RUN_W-1:0] mid_rl;
    logic             mid_hv;
    logic             lit_go;
    logic [RUN_W-1:0] lit_cnt;
    logic             sa_go, sc_go;
    logic [HDR_W-1:0] sa_hdr, sc_hdr;
    logic [RUN_W-1:0] lit_base;
    logic [RUN_W-1:0] lit_left;
    logic             last_row;
    t_dp_cmd          cmd;

    assign o_in_stall = (r_state != S_IDLE);
    assign lit_base   = {r_row, {BANK_W{1'b0}}};
    assign lit_left   = r_lit_cnt - lit_base;
    assign last_row   = (lit_left <= RUN_W'(LANES));

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_rl      = r_rl;
        n_hv      = r_hv;
        n_lit_cnt = r_lit_cnt;
        n_row     = r_row;
        n_s0_go   = r_s0_go;
        n_s0_hdr  = r_s0_hdr;
        n_s1_go   = r_s1_go;
        n_s1_hdr  = r_s1_hdr;
        n_fin     = r_fin;
        cmd       = '0;
        cmd.src   = SRC_LIT;
        mid_mode  = r_mode;
        mid_rl    = r_rl;
        mid_hv    = r_hv;
        lit_go    = 1'b0;
        lit_cnt   = r_rl;
        sa_go     = 1'b0;
        sa_hdr    = '0;
        sc_go     = 1'b0;
        sc_hdr    = '0;

        // Effect of the incoming pixel on the run, before the end-of-image close.
        case (r_mode)
            M_LIT: begin
                if (!i_status.eq) begin
                    cmd.we1 = 1'b1;
                    mid_rl  = r_rl + 1'b1;
                    if (mid_rl == MAX_RUN_L) begin
                        lit_go   = 1'b1;
                        lit_cnt  = MAX_RUN_L;
                        mid_mode = M_IDLE;
                        mid_rl   = '0;
                    end
                end else begin
                    lit_go   = 1'b1;
                    lit_cnt  = r_rl;
                    mid_mode = M_REP;
                    mid_rl   = RUN_W'(2);
                end
            end
            M_REP: begin
                if (i_status.eq) begin
                    mid_rl = r_rl + 1'b1;
                end else begin
                    sa_go      = 1'b1;
                    sa_hdr     = {1'b1, r_rl};
                    cmd.s0_old = 1'b1;
                    mid_mode   = M_IDLE;
                    mid_rl     = '0;
                end
            end
            default: begin
                if (!r_hv) begin
                    mid_hv = 1'b1;
                end else if (!i_status.eq) begin
                    cmd.we1  = 1'b1;
                    mid_rl   = RUN_W'(1);
                    mid_mode = M_LIT;
                end else begin
                    mid_mode = M_REP;
                    mid_rl   = RUN_W'(2);
                end
            end
        endcase

        // A repeat that reaches the maximum length closes at once.
        if (mid_mode == M_REP && mid_rl == MAX_RUN_L) begin
            sa_go    = 1'b1;
            sa_hdr   = {1'b1, MAX_RUN_L};
            mid_mode = M_IDLE;
            mid_rl   = '0;
            mid_hv   = 1'b0;
        end

        cmd.wa1 = r_rl;
        cmd.wa2 = mid_rl;

        if (i_final_pixel) begin
            case (mid_mode)
                M_LIT: begin
                    cmd.we2 = 1'b1;
                    lit_go  = 1'b1;
                    lit_cnt = mid_rl + 1'b1;
                end
                M_REP: begin
                    sc_go  = 1'b1;
                    sc_hdr = {1'b1, mid_rl};
                end
                default: begin
                    sc_go  = mid_hv;
                    sc_hdr = HDR_SINGLE;
                end
            endcase
            mid_mode = M_IDLE;
            mid_rl   = '0;
            mid_hv   = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_mode     = mid_mode;
                    n_rl       = mid_rl;
                    n_hv       = mid_hv;
                    n_lit_cnt  = lit_cnt;
                    n_row      = '0;
                    n_s0_go    = sa_go || sc_go;
                    n_s0_hdr   = sa_go ? sa_hdr : sc_hdr;
                    n_s1_go    = sa_go && sc_go;
                    n_s1_hdr   = sc_hdr;
                    n_fin      = i_final_pixel;
                    if (lit_go) begin
                        n_state = S_LIT;
                    end else if (sa_go || sc_go) begin
                        n_state = S_SNG0;
                    end
                end else begin
                    cmd.s0_old = 1'b0;
                    cmd.we1    = 1'b0;
                    cmd.we2    = 1'b0;
                end
            end
            S_LIT: begin
                if (i_status.ld_ok) begin
                    cmd.load       = 1'b1;
                    cmd.src        = SRC_LIT;
                    cmd.row        = r_row;
                    cmd.take       = last_row ? lit_left[TAKE_W-1:0] : TAKE_W'(LANES);
                    cmd.has_header = (r_row == '0);
                    cmd.header     = (r_row == '0) ? {1'b0, r_lit_cnt} : '0;
                    cmd.last       = last_row && !r_s0_go;
                    if (last_row) begin
                        n_state = r_s0_go ? S_SNG0 : S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            S_SNG0: begin
                if (i_status.ld_ok) begin
                    cmd.load       = 1'b1;
                    cmd.src        = SRC_S0;
                    cmd.take       = TAKE_W'(1);
                    cmd.has_header = 1'b1;
                    cmd.header     = r_s0_hdr;
                    cmd.last       = !r_s1_go;
                    n_state        = r_s1_go ? S_SNG1 : S_IDLE;
                end
            end
            S_SNG1: begin
                if (i_status.ld_ok) begin
                    cmd.load       = 1'b1;
                    cmd.src        = SRC_S1;
                    cmd.take       = TAKE_W'(1);
                    cmd.has_header = 1'b1;
                    cmd.header     = r_s1_hdr;
                    cmd.last       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        cmd.done = cmd.last && r_fin;
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_IDLE;
            r_rl    <= '0;
            r_hv    <= 1'b0;
            r_s0_go <= 1'b0;
            r_s1_go <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_rl    <= n_rl;
            r_hv    <= n_hv;
            r_s0_go <= n_s0_go;
            r_s1_go <= n_s1_go;
            r_fin   <= n_fin;
        end
        r_lit_cnt <= n_lit_cnt;
        r_row     <= n_row;
        r_s0_hdr  <= n_s0_hdr;
        r_s1_hdr  <= n_s1_hdr;
    end

    `PRLE_ASSERT_NOW(a_rep_len, i_clk, i_rst_n, r_mode == M_REP,
        (r_rl >= RUN_W'(2)) && (r_rl < MAX_RUN_L), "repeat length out of range")
    `PRLE_ASSERT_NOW(a_lit_len, i_clk, i_rst_n, r_mode == M_LIT,
        r_hv && (r_rl != '0) && (r_rl < MAX_RUN_L), "literal length out of range")
    `PRLE_ASSERT_NOW(a_lit_rows, i_clk, i_rst_n, r_state == S_LIT,
        r_lit_cnt > lit_base, "literal read past the end of the packet")
    `PRLE_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, cmd.load && cmd.last,
        r_state == S_IDLE, "sequencer busy after the last result of a transaction")

endmodule

FILE: hdl/pixel_run_length_encoder_core.sv
// Top level of the pixel run-length encoder.
// Packs a pixel stream into run-length packets: runs of 2 to 127 equal pixels become
// header 128+length and one pixel, other pixels become literal packets of header length
// followed by the pixels, with each result transaction carrying up to four pixels. When an
// input transaction closes packets, the sequencer then emits the result transactions in
// turn: ceil(n/4) for a literal packet of n pixels, one row of the four-bank literal store
// read per cycle while the output is not stalled, plus one for each single-pixel packet (at
// most 33 results for one input). Input is stalled while results are being loaded; the last
// result waits in the output register while the next input transaction is taken. The
// literal store needs no clearing after reset. Channel count is set through the
// configuration channel (3 RGB, 4 RGBA) and should be written only between transactions.
module pixel_run_length_encoder_core
    import prle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CH_W-1:0]   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_final_pixel,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_has_header,
    output logic [HDR_W-1:0]  o_header,
    output logic [TAKE_W-1:0] o_pixel_count,
    output logic [PIX_W-1:0]  o_pixel_a,
    output logic [PIX_W-1:0]  o_pixel_b,
    output logic [PIX_W-1:0]  o_pixel_c,
    output logic [PIX_W-1:0]  o_pixel_d,
    output logic              o_last_of_step,
    output logic              o_image_done
);

    t_dp_cmd    cmd;
    t_dp_status status;

    prle_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_final_pixel (i_final_pixel),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    prle_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_pixel        (i_pixel),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_has_header   (o_has_header),
        .o_header       (o_header),
        .o_pixel_count  (o_pixel_count),
        .o_pixel_a      (o_pixel_a),
        .o_pixel_b      (o_pixel_b),
        .o_pixel_c      (o_pixel_c),
        .o_pixel_d      (o_pixel_d),
        .o_last_of_step (o_last_of_step),
        .o_image_done   (o_image_done)
    );

endmodule
